[rtl/pwt_pkg.sv]
// pwt_pkg: widths, codes and control/status types of the pressure watermark tuner
// depends on nothing; imported by the interfaces and every rtl module but pwt_ram
`default_nettype none

package pwt_pkg;

    localparam int MARK_W     = 48;
    localparam int RATIO_W    = 16;
    localparam int WIN_W      = 7;
    localparam int LEVEL_W    = 2;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;
    // sums of two marks stay exact in one extra bit
    localparam int ALU_W      = MARK_W + 1;
    // a sample count fits 11 bits if the user keeps history depth at most 1024; not enforced here
    localparam int HIST_CNT_W = 11;
    localparam int PROD_W     = RATIO_W + HIST_CNT_W;

    // pressure levels
    localparam logic [LEVEL_W-1:0] LVL_BELOW = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_LOW   = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_HIGH  = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_TOP   = 2'd3;

    // signal actions
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ALL  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POOL = 2'd2;

    // ratio test outcome
    localparam logic [1:0] RT_UND = 2'd0;
    localparam logic [1:0] RT_MET = 2'd1;
    localparam logic [1:0] RT_NOT = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOP_LIMIT       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK_START  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK_START = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_RATIO_MIN   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_RATIO_MIN  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_WINDOW      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_WINDOW     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_STEP       = 4'd7;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic               wr_en;
        logic [LEVEL_W-1:0] wr_level;
        logic               start;
        logic [WIN_W-1:0]   low_window;
        logic [WIN_W-1:0]   high_window;
    } hist_ctrl_t;

    typedef struct packed {
        logic                  done;
        logic [HIST_CNT_W-1:0] top_over;
        logic [HIST_CNT_W-1:0] top_under;
        logic [HIST_CNT_W-1:0] high_over;
        logic [HIST_CNT_W-1:0] high_under;
    } hist_stat_t;

endpackage

`default_nettype wire

[rtl/pwt_if.sv]
// pwt_if: valid/ready channel interfaces for polls, results and register writes
// depends on pwt_pkg
`default_nettype none

interface pwt_poll_if import pwt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MARK_W-1:0] used_bytes;

    modport source (output valid, output used_bytes, input ready);
    modport sink   (input valid, input used_bytes, output ready);
endinterface

interface pwt_result_if import pwt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LEVEL_W-1:0]  pressure_level;
    logic [MARK_W-1:0]   low_mark;
    logic [MARK_W-1:0]   high_mark;
    logic                notify_all;
    logic [ACTION_W-1:0] signal_action;

    modport source (output valid, output pressure_level, output low_mark, output high_mark,
                    output notify_all, output signal_action, input ready);
    modport sink   (input valid, input pressure_level, input low_mark, input high_mark,
                    input notify_all, input signal_action, output ready);
endinterface

interface pwt_cfg_if import pwt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/pwt_ram.sv]
// pwt_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`default_nettype none

module pwt_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/pwt_alu.sv]
// pwt_alu: shared add/subtract unit with carry/borrow and zero flags
// depends on pwt_pkg
`default_nettype none

module pwt_alu import pwt_pkg::*; (
    input  wire alu_op_t          op,
    input  wire logic [ALU_W-1:0] a,
    input  wire logic [ALU_W-1:0] b,
    output logic      [ALU_W-1:0] y,
    output logic                  neg,
    output logic                  zero
);

    logic [ALU_W:0] full;

    always_comb
    begin
        unique case (op)
            ALU_ADD: full = {1'b0, a} + {1'b0, b};
            ALU_SUB: full = {1'b0, a} - {1'b0, b};
            default: full = '0;
        endcase
    end

    assign y    = full[ALU_W-1:0];
    // borrow out of a subtract means a < b
    assign neg  = full[ALU_W];
    assign zero = (full == '0);

endmodule

`default_nettype wire

[rtl/pwt_hist.sv]
// pwt_hist: level history ring in ram, walked newest first to count samples per window
// depends on pwt_pkg and pwt_ram
`default_nettype none

module pwt_hist import pwt_pkg::*; #(
    parameter int HISTORY_DEPTH = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire hist_ctrl_t ctrl,
    output hist_stat_t      stat
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(HISTORY_DEPTH);

    function automatic logic [CW-1:0] clamp_win(input logic [WIN_W-1:0] w);
        if (32'(w) > HISTORY_DEPTH)
        begin
            return DEPTH_CNT;
        end
        return CW'(w);
    endfunction

    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [AW-1:0]      rd_addr_reg, rd_addr_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      num_reg, num_next;
    logic [CW-1:0]      lw_reg, lw_next;
    logic [CW-1:0]      hw_reg, hw_next;
    logic               active_reg, active_next;
    logic               pv_reg, pv_next;
    logic [CW-1:0]      pidx_reg, pidx_next;
    logic               walk_reg, walk_next;
    logic [CW-1:0]      at_reg, at_next;
    logic [CW-1:0]      bt_reg, bt_next;
    logic [CW-1:0]      ah_reg, ah_next;
    logic [CW-1:0]      bh_reg, bh_next;
    logic [LEVEL_W-1:0] rdata;
    logic [LEVEL_W-1:0] lv;
    logic [CW-1:0]      lw_start, hw_start;
    logic               done;

    pwt_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.wr_en),
        .waddr (tail_reg),
        .wdata (ctrl.wr_level),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    assign lw_start = clamp_win(ctrl.low_window);
    assign hw_start = clamp_win(ctrl.high_window);
    assign done     = walk_reg && !active_reg && !pv_reg;
    // entries never written since reset read as the lowest level
    assign lv       = (pidx_reg < fill_reg) ? rdata : LVL_BELOW;

    always_comb
    begin
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        rd_addr_next = rd_addr_reg;
        idx_next     = idx_reg;
        num_next     = num_reg;
        lw_next      = lw_reg;
        hw_next      = hw_reg;
        active_next  = active_reg;
        pv_next      = 1'b0;
        pidx_next    = pidx_reg;
        walk_next    = walk_reg;
        at_next      = at_reg;
        bt_next      = bt_reg;
        ah_next      = ah_reg;
        bh_next      = bh_reg;

        if (ctrl.wr_en)
        begin
            tail_next = (tail_reg == LAST_ADDR) ? '0 : tail_reg + 1'b1;
            if (fill_reg != DEPTH_CNT)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end

        if (ctrl.start)
        begin
            // newest sample is the one written in this cycle
            rd_addr_next = tail_reg;
            idx_next     = '0;
            lw_next      = lw_start;
            hw_next      = hw_start;
            num_next     = (lw_start > hw_start) ? lw_start : hw_start;
            active_next  = (lw_start != '0) || (hw_start != '0);
            walk_next    = 1'b1;
            at_next      = '0;
            bt_next      = '0;
            ah_next      = '0;
            bh_next      = '0;
        end
        else
        begin
            if (active_reg)
            begin
                pv_next      = 1'b1;
                pidx_next    = idx_reg;
                idx_next     = CW'(idx_reg + 1'b1);
                rd_addr_next = (rd_addr_reg == '0) ? LAST_ADDR : rd_addr_reg - 1'b1;
                if (CW'(idx_reg + 1'b1) == num_reg)
                begin
                    active_next = 1'b0;
                end
            end
            if (pv_reg)
            begin
                if (pidx_reg < hw_reg)
                begin
                    if (lv == LVL_TOP)
                    begin
                        at_next = at_reg + 1'b1;
                    end
                    else
                    begin
                        bt_next = bt_reg + 1'b1;
                    end
                end
                if (pidx_reg < lw_reg)
                begin
                    if (lv == LVL_HIGH || lv == LVL_TOP)
                    begin
                        ah_next = ah_reg + 1'b1;
                    end
                    else
                    begin
                        bh_next = bh_reg + 1'b1;
                    end
                end
            end
            if (done)
            begin
                walk_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg   <= '0;
            fill_reg   <= '0;
            active_reg <= 1'b0;
            pv_reg     <= 1'b0;
            walk_reg   <= 1'b0;
        end
        else
        begin
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            active_reg <= active_next;
            pv_reg     <= pv_next;
            walk_reg   <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        idx_reg     <= idx_next;
        num_reg     <= num_next;
        lw_reg      <= lw_next;
        hw_reg      <= hw_next;
        pidx_reg    <= pidx_next;
        at_reg      <= at_next;
        bt_reg      <= bt_next;
        ah_reg      <= ah_next;
        bh_reg      <= bh_next;
    end

    assign stat.done       = done;
    assign stat.top_over   = HIST_CNT_W'(at_reg);
    assign stat.top_under  = HIST_CNT_W'(bt_reg);
    assign stat.high_over  = HIST_CNT_W'(ah_reg);
    assign stat.high_under = HIST_CNT_W'(bh_reg);

`ifndef NO_ASSERTIONS
    a_top_window_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (CW'(at_reg + bt_reg) == hw_reg))
        else $error("top window count does not match the window");

    a_high_window_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (CW'(ah_reg + bh_reg) == lw_reg))
        else $error("high window count does not match the window");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (walk_reg && (pidx_reg < num_reg)))
        else $error("history read outside the walk");
`endif

endmodule

`default_nettype wire

[rtl/pressure_watermark_tuner.sv]
// pressure_watermark_tuner: a poll at level 0 runs the three compares and goes to done; at level 1
// it also walks n history entries, n the larger window clamped to HISTORY_DEPTH, then runs the
// ratio tests and raises; at level 2 or 3 it adds the equality checks and the lowering steps;
// the history walk reads one ram entry per cycle, and compares and adjustments share one adder.
// one poll in work at a time, the next is taken the cycle after the result register loads.
// rst_n clears state asynchronously; history reads as level 0 via a fill count, no clear pass.
`default_nettype none

module pressure_watermark_tuner import pwt_pkg::*; #(
    parameter int HISTORY_DEPTH = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pwt_poll_if.sink      poll,
    pwt_result_if.source  result,
    pwt_cfg_if.sink       cfg
);

    localparam int SW = 5;
    localparam logic [SW-1:0] S_IDLE     = 5'd0;
    localparam logic [SW-1:0] S_CMP_TOP  = 5'd1;
    localparam logic [SW-1:0] S_CMP_HIGH = 5'd2;
    localparam logic [SW-1:0] S_CMP_LOW  = 5'd3;
    localparam logic [SW-1:0] S_WALK     = 5'd4;
    localparam logic [SW-1:0] S_MUL_H    = 5'd5;
    localparam logic [SW-1:0] S_TST_H    = 5'd6;
    localparam logic [SW-1:0] S_MUL_L    = 5'd7;
    localparam logic [SW-1:0] S_TST_L    = 5'd8;
    localparam logic [SW-1:0] S_ADD_H    = 5'd9;
    localparam logic [SW-1:0] S_CLP_H    = 5'd10;
    localparam logic [SW-1:0] S_ADD_L    = 5'd11;
    localparam logic [SW-1:0] S_CLP_L    = 5'd12;
    localparam logic [SW-1:0] S_EQ_TOP   = 5'd13;
    localparam logic [SW-1:0] S_EQ_HL    = 5'd14;
    localparam logic [SW-1:0] S_SUB_L    = 5'd15;
    localparam logic [SW-1:0] S_SUB_H    = 5'd16;
    localparam logic [SW-1:0] S_MAX_H    = 5'd17;
    localparam logic [SW-1:0] S_DONE     = 5'd18;

    logic [SW-1:0]       state_reg, state_next;

    // configuration
    logic [MARK_W-1:0]   top_reg;
    logic [MARK_W-1:0]   step_reg;
    logic [RATIO_W-1:0]  lratio_reg;
    logic [RATIO_W-1:0]  hratio_reg;
    logic [WIN_W-1:0]    lwin_reg;
    logic [WIN_W-1:0]    hwin_reg;

    // working watermarks
    logic [MARK_W-1:0]   low_reg, low_next;
    logic [MARK_W-1:0]   high_reg, high_next;

    // per-poll work registers
    logic [MARK_W-1:0]   used_reg, used_next;
    logic                gt_top_reg, gt_top_next;
    logic                gt_high_reg, gt_high_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [1:0]          hr_reg, hr_next;
    logic [1:0]          lr_reg, lr_next;
    logic [ALU_W-1:0]    sum_reg, sum_next;
    logic                eq_top_reg, eq_top_next;
    logic                hdec_reg, hdec_next;
    logic [ACTION_W-1:0] action_reg, action_next;

    // result register
    logic                res_valid_reg, res_valid_next;
    logic [LEVEL_W-1:0]  res_level_reg, res_level_next;
    logic [MARK_W-1:0]   res_low_reg, res_low_next;
    logic [MARK_W-1:0]   res_high_reg, res_high_next;
    logic [ACTION_W-1:0] res_action_reg, res_action_next;

    alu_op_t             alu_op;
    logic [ALU_W-1:0]    alu_a, alu_b, alu_y;
    logic                alu_neg, alu_zero;
    logic [LEVEL_W-1:0]  level_cmp;
    logic                out_free;
    logic                poll_fire;
    hist_ctrl_t          hctrl;
    hist_stat_t          hstat;

    assign poll.ready = (state_reg == S_IDLE);
    assign poll_fire  = poll.valid && poll.ready;
    assign cfg.ready  = 1'b1;
    assign out_free   = !res_valid_reg || result.ready;

    assign level_cmp = gt_top_reg  ? LVL_TOP  :
                       gt_high_reg ? LVL_HIGH :
                       alu_neg     ? LVL_LOW  : LVL_BELOW;

    pwt_alu u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .y    (alu_y),
        .neg  (alu_neg),
        .zero (alu_zero)
    );

    pwt_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (hctrl),
        .stat  (hstat)
    );

    always_comb
    begin
        hctrl.wr_en       = (state_reg == S_CMP_LOW);
        hctrl.wr_level    = level_cmp;
        hctrl.start       = (state_reg == S_CMP_LOW) && (level_cmp != LVL_BELOW);
        hctrl.low_window  = lwin_reg;
        hctrl.high_window = hwin_reg;
    end

    // operand selection for the shared adder
    always_comb
    begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            S_CMP_TOP:
            begin
                alu_a = {1'b0, top_reg};
                alu_b = {1'b0, used_reg};
            end
            S_CMP_HIGH:
            begin
                alu_a = {1'b0, high_reg};
                alu_b = {1'b0, used_reg};
            end
            S_CMP_LOW:
            begin
                alu_a = {1'b0, low_reg};
                alu_b = {1'b0, used_reg};
            end
            S_TST_H:
            begin
                alu_a = ALU_W'(hstat.top_under);
                alu_b = ALU_W'(prod_reg);
            end
            S_TST_L:
            begin
                alu_a = ALU_W'(hstat.high_under);
                alu_b = ALU_W'(prod_reg);
            end
            S_ADD_H:
            begin
                alu_op = ALU_ADD;
                alu_a  = {1'b0, high_reg};
                alu_b  = {1'b0, step_reg};
            end
            S_CLP_H:
            begin
                alu_a = sum_reg;
                alu_b = {1'b0, top_reg};
            end
            S_ADD_L:
            begin
                alu_op = ALU_ADD;
                alu_a  = {1'b0, low_reg};
                alu_b  = {1'b0, step_reg};
            end
            S_CLP_L:
            begin
                alu_a = sum_reg;
                alu_b = {1'b0, high_reg};
            end
            S_EQ_TOP:
            begin
                alu_a = {1'b0, high_reg};
                alu_b = {1'b0, top_reg};
            end
            S_EQ_HL:
            begin
                alu_a = {1'b0, high_reg};
                alu_b = {1'b0, low_reg};
            end
            S_SUB_L:
            begin
                alu_a = {1'b0, low_reg};
                alu_b = {1'b0, step_reg};
            end
            S_SUB_H:
            begin
                alu_a = {1'b0, high_reg};
                alu_b = {1'b0, step_reg};
            end
            S_MAX_H:
            begin
                alu_a = sum_reg;
                alu_b = {1'b0, low_reg};
            end
            default:
            begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        used_next       = used_reg;
        gt_top_next     = gt_top_reg;
        gt_high_next    = gt_high_reg;
        level_next      = level_reg;
        prod_next       = prod_reg;
        hr_next         = hr_reg;
        lr_next         = lr_reg;
        sum_next        = sum_reg;
        eq_top_next     = eq_top_reg;
        hdec_next       = hdec_reg;
        action_next     = action_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        res_level_next  = res_level_reg;
        res_low_next    = res_low_reg;
        res_high_next   = res_high_reg;
        res_action_next = res_action_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (poll_fire)
                begin
                    used_next  = poll.used_bytes;
                    state_next = S_CMP_TOP;
                end
            end
            S_CMP_TOP:
            begin
                gt_top_next = alu_neg;
                state_next  = S_CMP_HIGH;
            end
            S_CMP_HIGH:
            begin
                gt_high_next = alu_neg;
                state_next   = S_CMP_LOW;
            end
            S_CMP_LOW:
            begin
                level_next  = level_cmp;
                action_next = ACT_NONE;
                state_next  = (level_cmp == LVL_BELOW) ? S_DONE : S_WALK;
            end
            S_WALK:
            begin
                if (hstat.done)
                begin
                    state_next = S_MUL_H;
                end
            end
            S_MUL_H:
            begin
                prod_next  = hratio_reg * hstat.top_over;
                state_next = S_TST_H;
            end
            S_TST_H:
            begin
                if (hstat.top_over == '0 && hstat.top_under == '0)
                begin
                    hr_next = RT_UND;
                end
                else
                begin
                    hr_next = alu_neg ? RT_NOT : RT_MET;
                end
                state_next = S_MUL_L;
            end
            S_MUL_L:
            begin
                prod_next  = lratio_reg * hstat.high_over;
                state_next = S_TST_L;
            end
            S_TST_L:
            begin
                if (hstat.high_over == '0 && hstat.high_under == '0)
                begin
                    lr_next = RT_UND;
                end
                else
                begin
                    lr_next = alu_neg ? RT_NOT : RT_MET;
                end
                state_next = S_ADD_H;
            end
            S_ADD_H:
            begin
                sum_next   = alu_y;
                state_next = S_CLP_H;
            end
            S_CLP_H:
            begin
                // saturating raise of the high mark at the top limit
                if (level_reg == LVL_HIGH && hr_reg == RT_MET)
                begin
                    high_next = alu_neg ? sum_reg[MARK_W-1:0] : top_reg;
                end
                state_next = S_ADD_L;
            end
            S_ADD_L:
            begin
                sum_next   = alu_y;
                state_next = S_CLP_L;
            end
            S_CLP_L:
            begin
                if (lr_reg == RT_MET)
                begin
                    low_next = alu_neg ? sum_reg[MARK_W-1:0] : high_reg;
                end
                state_next = (level_reg == LVL_LOW) ? S_DONE : S_EQ_TOP;
            end
            S_EQ_TOP:
            begin
                eq_top_next = alu_zero;
                state_next  = S_EQ_HL;
            end
            S_EQ_HL:
            begin
                if (level_reg == LVL_TOP && !eq_top_reg)
                begin
                    action_next = ACT_ALL;
                end
                else if (!alu_zero)
                begin
                    action_next = ACT_POOL;
                end
                else
                begin
                    action_next = ACT_NONE;
                end
                state_next = S_SUB_L;
            end
            S_SUB_L:
            begin
                if (lr_reg == RT_NOT)
                begin
                    low_next = alu_neg ? '0 : alu_y[MARK_W-1:0];
                end
                state_next = S_SUB_H;
            end
            S_SUB_H:
            begin
                sum_next  = alu_y;
                hdec_next = 1'b0;
                if (level_reg == LVL_TOP && hr_reg == RT_NOT)
                begin
                    if (alu_neg)
                    begin
                        high_next = '0;
                    end
                    else
                    begin
                        hdec_next = 1'b1;
                    end
                end
                state_next = S_MAX_H;
            end
            S_MAX_H:
            begin
                // lowered high mark does not drop below the low mark; a step larger than the high mark zeroes it
                if (hdec_reg)
                begin
                    high_next = alu_neg ? low_reg : sum_reg[MARK_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_level_next  = level_reg;
                    res_low_next    = low_reg;
                    res_high_next   = high_reg;
                    res_action_next = action_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // writing a start register also loads the working watermark
        if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == REG_LOW_MARK_START)
            begin
                low_next = cfg.data;
            end
            if (cfg.index == REG_HIGH_MARK_START)
            begin
                high_next = cfg.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            top_reg       <= '0;
            step_reg      <= '0;
            lratio_reg    <= RATIO_W'(1);
            hratio_reg    <= RATIO_W'(1);
            lwin_reg      <= WIN_W'(64);
            hwin_reg      <= WIN_W'(64);
            low_reg       <= '0;
            high_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_TOP_LIMIT:       top_reg    <= cfg.data;
                    REG_LOW_MARK_START,
                    REG_HIGH_MARK_START: ;
                    REG_LOW_RATIO_MIN:   lratio_reg <= cfg.data[RATIO_W-1:0];
                    REG_HIGH_RATIO_MIN:  hratio_reg <= cfg.data[RATIO_W-1:0];
                    REG_LOW_WINDOW:      lwin_reg   <= cfg.data[WIN_W-1:0];
                    REG_HIGH_WINDOW:     hwin_reg   <= cfg.data[WIN_W-1:0];
                    REG_MARK_STEP:       step_reg   <= cfg.data;
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        used_reg       <= used_next;
        gt_top_reg     <= gt_top_next;
        gt_high_reg    <= gt_high_next;
        level_reg      <= level_next;
        prod_reg       <= prod_next;
        hr_reg         <= hr_next;
        lr_reg         <= lr_next;
        sum_reg        <= sum_next;
        eq_top_reg     <= eq_top_next;
        hdec_reg       <= hdec_next;
        action_reg     <= action_next;
        res_level_reg  <= res_level_next;
        res_low_reg    <= res_low_next;
        res_high_reg   <= res_high_next;
        res_action_reg <= res_action_next;
    end

    assign result.valid          = res_valid_reg;
    assign result.pressure_level = res_level_reg;
    assign result.low_mark       = res_low_reg;
    assign result.high_mark      = res_high_reg;
    assign result.notify_all     = (res_level_reg != LVL_BELOW);
    assign result.signal_action  = res_action_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_poll: assert property (@(posedge clk) disable iff (!rst_n)
        poll_fire |=> !poll.ready)
        else $error("poll taken while a poll is still in work");

    a_no_action_below_high: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.pressure_level == LVL_BELOW ||
                          result.pressure_level == LVL_LOW))
        |-> (result.signal_action == ACT_NONE))
        else $error("signal action reported below the high level");

    a_walk_only_when_pressured: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (level_reg != LVL_BELOW))
        else $error("history walk at the lowest level");

    a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (result.valid && state_reg == S_IDLE))
        else $error("finished poll did not reach the result register");
`endif

endmodule

`default_nettype wire

[test/pressure_watermark_tuner_tb.sv]
// pressure_watermark_tuner_tb: self-checking bench for the pressure watermark tuner,
// a directed script followed by randomized register phases, all results checked in order
// depends on pwt_pkg, the channel interfaces in pwt_if and the rtl top
`timescale 1ns / 100ps

module pressure_watermark_tuner_tb;
    import pwt_pkg::*;

    localparam int              RING_DEPTH      = 64;
    localparam longint unsigned MARK_MAX        = (64'd1 << MARK_W) - 64'd1;
    localparam int              PHASES          = 10;
    localparam int              POLLS_PER_PHASE = 95;
    localparam int              HOLD_CYCLES     = 300;
    // a poll walks the most history entries with both windows at 64 or more
    localparam int              DRAIN_CYCLES    = 100;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [MARK_W-1:0]   low_mark;
        logic [MARK_W-1:0]   high_mark;
        logic                notify;
        logic [ACTION_W-1:0] action;
    } tuner_out_t;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] idx;
        logic [MARK_W-1:0]    val;
        bit                   typed;
        tuner_out_t           want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_req = 1'b0;

    pwt_poll_if   poll_ch ();
    pwt_result_if res_ch ();
    pwt_cfg_if    cfg_ch ();

    pressure_watermark_tuner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always #6 clk = ~clk;

    // shadow copy of the block state and registers
    logic [LEVEL_W-1:0] level_ring [RING_DEPTH];
    int                 ring_tail = 0;
    logic [MARK_W-1:0]  low_now = '0;
    logic [MARK_W-1:0]  high_now = '0;
    logic [MARK_W-1:0]  top_reg = '0;
    logic [MARK_W-1:0]  step_reg = '0;
    logic [RATIO_W-1:0] low_ratio = 16'd1;
    logic [RATIO_W-1:0] high_ratio = 16'd1;
    logic [WIN_W-1:0]   low_window = 7'd64;
    logic [WIN_W-1:0]   high_window = 7'd64;

    tuner_out_t  predicted_reports [$];
    script_row_t script [$];
    int          error_count = 0;

    initial
    begin
        for (int i = 0; i < RING_DEPTH; i++)
            level_ring[i] = LVL_BELOW;
    end

    function automatic longint unsigned rand48();
        return {$urandom, $urandom} & MARK_MAX;
    endfunction

    function automatic logic [1:0] ratio_verdict(input int below, input int above,
                                                 input logic [RATIO_W-1:0] ratio);
        if (above == 0)
            return (below > 0) ? RT_MET : RT_UND;
        return (longint'(below) >= longint'(ratio) * longint'(above)) ? RT_MET : RT_NOT;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TOP_LIMIT:       top_reg = data;
            REG_LOW_MARK_START:  low_now = data;
            REG_HIGH_MARK_START: high_now = data;
            REG_LOW_RATIO_MIN:   low_ratio = data[RATIO_W-1:0];
            REG_HIGH_RATIO_MIN:  high_ratio = data[RATIO_W-1:0];
            REG_LOW_WINDOW:      low_window = data[WIN_W-1:0];
            REG_HIGH_WINDOW:     high_window = data[WIN_W-1:0];
            REG_MARK_STEP:       step_reg = data;
            default:             ;
        endcase
    endfunction

    // classify one poll, push it into the ring and adapt the watermarks
    function automatic tuner_out_t tune_poll(input logic [MARK_W-1:0] used);
        logic [LEVEL_W-1:0]  lvl;
        logic [1:0]          low_verdict, high_verdict;
        logic [ACTION_W-1:0] act;
        longint unsigned     lo, hi, stp, sum, diff;
        int                  win_lo, win_hi, slot, i;
        int                  top_over, top_under, high_over, high_under;
        tuner_out_t          r;
        lo = low_now;
        hi = high_now;
        stp = step_reg;
        act = ACT_NONE;
        if (used > top_reg)
            lvl = LVL_TOP;
        else if (used > high_now)
            lvl = LVL_HIGH;
        else if (used > low_now)
            lvl = LVL_LOW;
        else
            lvl = LVL_BELOW;
        level_ring[ring_tail] = lvl;
        ring_tail = (ring_tail + 1) % RING_DEPTH;
        if (lvl != LVL_BELOW)
        begin
            win_lo = (int'(low_window) > RING_DEPTH) ? RING_DEPTH : int'(low_window);
            win_hi = (int'(high_window) > RING_DEPTH) ? RING_DEPTH : int'(high_window);
            top_over = 0;
            top_under = 0;
            high_over = 0;
            high_under = 0;
            // newest sample first
            for (i = 0; i < RING_DEPTH; i++)
            begin
                slot = (ring_tail + RING_DEPTH - 1 - i) % RING_DEPTH;
                if (i < win_hi)
                begin
                    if (level_ring[slot] == LVL_TOP)
                        top_over++;
                    else
                        top_under++;
                end
                if (i < win_lo)
                begin
                    if (level_ring[slot] >= LVL_HIGH)
                        high_over++;
                    else
                        high_under++;
                end
            end
            high_verdict = ratio_verdict(top_under, top_over, high_ratio);
            low_verdict = ratio_verdict(high_under, high_over, low_ratio);
            if (lvl == LVL_HIGH && high_verdict == RT_MET)
            begin
                sum = hi + stp;
                hi = (sum < top_reg) ? sum : top_reg;
            end
            if (low_verdict == RT_MET)
            begin
                sum = lo + stp;
                lo = (sum < hi) ? sum : hi;
            end
            if (lvl >= LVL_HIGH)
            begin
                if (lvl == LVL_TOP && hi != top_reg)
                    act = ACT_ALL;
                else if (hi != lo)
                    act = ACT_POOL;
                else
                    act = ACT_NONE;
                if (low_verdict == RT_NOT)
                    lo = (stp > lo) ? 0 : lo - stp;
                if (lvl == LVL_TOP && high_verdict == RT_NOT)
                begin
                    if (stp > hi)
                        hi = 0;
                    else
                    begin
                        diff = hi - stp;
                        hi = (diff > lo) ? diff : lo;
                    end
                end
            end
        end
        low_now = lo[MARK_W-1:0];
        high_now = hi[MARK_W-1:0];
        r.level = lvl;
        r.low_mark = low_now;
        r.high_mark = high_now;
        r.notify = (lvl != LVL_BELOW);
        r.action = act;
        return r;
    endfunction

    function automatic longint unsigned span(input longint unsigned lo_b,
                                             input longint unsigned hi_b);
        if (lo_b > hi_b)
            return rand48();
        return lo_b + rand48() % (hi_b - lo_b + 1);
    endfunction

    // usage value for one region: zero, the maximum, random, or one band around the current marks
    function automatic logic [MARK_W-1:0] pick_used(input int region);
        longint unsigned v;
        case (region)
            0:       v = 0;
            1:       v = MARK_MAX;
            2:       v = rand48();
            3:       v = span(0, low_now);
            4:       v = span(longint'(low_now) + 1, high_now);
            5:       v = span(longint'(high_now) + 1, top_reg);
            6:       v = span(longint'(top_reg) + 1, MARK_MAX);
            7:       v = low_now + $urandom_range(0, 1);
            8:       v = high_now + $urandom_range(0, 1);
            default: v = top_reg + $urandom_range(0, 1);
        endcase
        return v[MARK_W-1:0];
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [MARK_W-1:0] val);
        script_row_t row;
        row.is_reg = 1'b1;
        row.idx = idx;
        row.val = val;
        row.typed = 1'b0;
        row.want = '0;
        script.insert(script.size(), row);
    endfunction

    function automatic void add_poll(input logic [MARK_W-1:0] used);
        script_row_t row;
        row.is_reg = 1'b0;
        row.idx = '0;
        row.val = used;
        row.typed = 1'b0;
        row.want = '0;
        script.insert(script.size(), row);
    endfunction

    function automatic void add_poll_known(input logic [MARK_W-1:0] used,
                                           input logic [LEVEL_W-1:0] lvl,
                                           input logic [MARK_W-1:0] lo,
                                           input logic [MARK_W-1:0] hi,
                                           input logic nfy,
                                           input logic [ACTION_W-1:0] act);
        script_row_t row;
        row.is_reg = 1'b0;
        row.idx = '0;
        row.val = used;
        row.typed = 1'b1;
        row.want = {lvl, lo, hi, nfy, act};
        script.insert(script.size(), row);
    endfunction

    task automatic offer_poll(input logic [MARK_W-1:0] used, input bit typed,
                              input tuner_out_t want);
        tuner_out_t forecast;
        poll_ch.used_bytes <= used;
        poll_ch.valid <= 1'b1;
        @(posedge clk);
        while (poll_ch.ready !== 1'b1)
            @(posedge clk);
        forecast = tune_poll(used);
        predicted_reports.insert(predicted_reports.size(), typed ? want : forecast);
    endtask

    task automatic wait_drained();
        poll_ch.valid <= 1'b0;
        @(posedge clk);
        while (predicted_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        apply_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // narrow registers get random junk in the unused upper data bits half the time
    function automatic logic [CFG_DATA_W-1:0] pad_narrow(input longint unsigned value,
                                                         input int width);
        longint unsigned keep;
        keep = (64'd1 << width) - 1;
        if ($urandom_range(0, 1) == 1)
            return (rand48() & ~keep) | (value & keep);
        return value & keep;
    endfunction

    task automatic program_phase(input int phase);
        longint unsigned      top, lo, hi, stp;
        longint unsigned      lr, hr, lw, hw;
        int                   rot, j;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
        top = rand48() >> $urandom_range(0, 32);
        lo = top / 100 * $urandom_range(10, 60);
        hi = top / 100 * $urandom_range(60, 99);
        stp = top / 100 * $urandom_range(0, 15);
        lr = $urandom_range(1, 6);
        hr = $urandom_range(1, 10);
        lw = $urandom_range(1, 64);
        hw = $urandom_range(1, 64);
        case (phase)
            0:
            begin
                top = MARK_MAX;
                lo = top / 100 * 40;
                hi = top / 100 * 80;
                stp = top / 100 * $urandom_range(1, 20);
                lr = 16'hffff;
                hr = 16'hffff;
                lw = 7'h7f;
                hw = 7'h7f;
            end
            1:
            begin
                top = 0;
                lo = 0;
                hi = 0;
                lr = 0;
                hr = 0;
                lw = 0;
                hw = 0;
            end
            2:
            begin
                lw = 1;
                hw = 1;
                lr = 1;
                hr = 1;
                stp = MARK_MAX;
            end
            3:
            begin
                // low start above high start
                lo = hi + top / 50;
                lw = 64;
                hw = 64;
            end
            4:
            begin
                lw = $urandom_range(65, 127);
                hw = $urandom_range(0, 3);
            end
            default: ;
        endcase
        rot = $urandom_range(0, 15);
        for (j = 0; j < 16; j++)
        begin
            idx = CFG_IDX_W'((j + rot) % 16);
            case (idx)
                REG_TOP_LIMIT:       data = top;
                REG_LOW_MARK_START:  data = lo;
                REG_HIGH_MARK_START: data = hi;
                REG_LOW_RATIO_MIN:   data = pad_narrow(lr, RATIO_W);
                REG_HIGH_RATIO_MIN:  data = pad_narrow(hr, RATIO_W);
                REG_LOW_WINDOW:      data = pad_narrow(lw, WIN_W);
                REG_HIGH_WINDOW:     data = pad_narrow(hw, WIN_W);
                REG_MARK_STEP:       data = stp;
                default:             data = rand48();
            endcase
            write_reg(idx, data);
        end
    endtask

    // result sink: stall pattern of its own plus one long hold on request
    initial
    begin : result_sink
        int          hold_left;
        int          cyc;
        logic [15:0] stall_pattern;
        hold_left = 0;
        cyc = 0;
        stall_pattern = '1;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req <= 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                cyc++;
                if (cyc % 150 == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       stall_pattern = '1;
                        1:       stall_pattern = 16'($urandom);
                        2:       stall_pattern = 16'($urandom | $urandom);
                        default: stall_pattern = 16'($urandom & $urandom);
                    endcase
                    if (stall_pattern == '0)
                        stall_pattern = 16'h0001;
                end
            end
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        tuner_out_t seen;
        tuner_out_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            seen = {res_ch.pressure_level, res_ch.low_mark, res_ch.high_mark,
                    res_ch.notify_all, res_ch.signal_action};
            if (predicted_reports.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: level %0d low %h high %h notify %0d action %0d",
                             seen.level, seen.low_mark, seen.high_mark, seen.notify,
                             seen.action);
            end
            else
            begin
                want = predicted_reports.pop_front();
                if (seen !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"mismatch (exp/act): level %0d/%0d low %h/%h high %h/%h",
                                  " notify %0d/%0d action %0d/%0d"},
                                 want.level, seen.level, want.low_mark, seen.low_mark,
                                 want.high_mark, seen.high_mark, want.notify, seen.notify,
                                 want.action, seen.action);
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAIL pressure_watermark_tuner");
        $finish;
    end

    initial
    begin : stimulus
        int phase, n, region, favor, gap, burst_left;
        bit steady;
        rst_n <= 1'b0;
        poll_ch.valid <= 1'b0;
        poll_ch.used_bytes <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;

        // everything zero after reset: marks, top limit and step
        add_poll_known(48'd0, LVL_BELOW, '0, '0, 1'b0, ACT_NONE);
        add_poll_known(48'd1, LVL_TOP, '0, '0, 1'b1, ACT_NONE);
        add_poll_known(MARK_MAX, LVL_TOP, '0, '0, 1'b1, ACT_NONE);
        add_reg(REG_TOP_LIMIT, MARK_MAX);
        add_poll_known(MARK_MAX, LVL_HIGH, '0, '0, 1'b1, ACT_NONE);
        add_poll_known(48'd0, LVL_BELOW, '0, '0, 1'b0, ACT_NONE);
        // band edges around low 5000, high 9000, top 20000
        add_reg(REG_MARK_STEP, 48'd1000);
        add_reg(REG_LOW_MARK_START, 48'd5000);
        add_reg(REG_HIGH_MARK_START, 48'd9000);
        add_reg(REG_TOP_LIMIT, 48'd20000);
        add_poll(48'd5000);
        add_poll(48'd5001);
        add_poll(48'd9000);
        add_poll(48'd9001);
        add_poll(48'd20000);
        add_poll(48'd20001);
        add_poll(MARK_MAX);
        add_poll(48'd0);
        // empty windows leave both marks undecided
        add_reg(REG_LOW_WINDOW, 48'd0);
        add_reg(REG_HIGH_WINDOW, 48'd0);
        add_poll(48'd9001);
        add_poll(48'd20001);
        // oversized windows saturate, zero ratios always pass
        add_reg(REG_LOW_WINDOW, 48'h7f);
        add_reg(REG_HIGH_WINDOW, 48'h7f);
        add_reg(REG_LOW_RATIO_MIN, 48'd0);
        add_reg(REG_HIGH_RATIO_MIN, 48'hffff_ffff_0000);
        add_poll(48'd20001);
        add_poll(48'd9001);
        // one-sample windows with the largest ratio
        add_reg(REG_LOW_WINDOW, 48'd1);
        add_reg(REG_HIGH_WINDOW, 48'd1);
        add_reg(REG_LOW_RATIO_MIN, 48'hffff);
        add_reg(REG_HIGH_RATIO_MIN, 48'hffff);
        add_poll(48'd20001);
        add_poll(48'd9001);
        // low start above high start
        add_reg(REG_LOW_MARK_START, 48'd30000);
        add_reg(REG_HIGH_MARK_START, 48'd100);
        add_poll(48'd50);
        add_poll(48'd150);
        add_poll(48'd25000);
        // indexes past the register list are ignored
        add_reg(4'd8, MARK_MAX);
        add_reg(4'd15, 48'h5a5a_5a5a_5a5a);
        add_poll(48'd15000);
        add_reg(REG_MARK_STEP, MARK_MAX);
        add_poll(48'd25000);
        add_poll(48'd10);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            if (script[r].is_reg)
            begin
                wait_drained();
                write_reg(script[r].idx, script[r].val);
            end
            else
                offer_poll(script[r].val, script[r].typed, script[r].want);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            program_phase(phase);
            favor = $urandom_range(3, 6);
            steady = (phase % 4 == 1) || (phase == 6);
            burst_left = $urandom_range(1, 24);
            for (n = 0; n < POLLS_PER_PHASE; n++)
            begin
                // long receiver hold while polls keep coming, fills the block
                if (phase == 6 && n == 20)
                    hold_req <= 1'b1;
                if (phase == 7 && n == 40)
                    wait_drained();
                region = ($urandom_range(0, 1) == 1) ? favor : $urandom_range(0, 9);
                offer_poll(pick_used(region), 1'b0, '0);
                burst_left--;
                if (burst_left == 0)
                begin
                    gap = steady ? 0 : $urandom_range(0, 12);
                    if (gap > 0)
                    begin
                        poll_ch.valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
            end
        end

        poll_ch.valid <= 1'b0;
        while (predicted_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS pressure_watermark_tuner");
        else
            $display("FAIL pressure_watermark_tuner");
        $finish;
    end

endmodule

[files.f]
rtl/pwt_pkg.sv
rtl/pwt_if.sv
rtl/pwt_ram.sv
rtl/pwt_alu.sv
rtl/pwt_hist.sv
rtl/pressure_watermark_tuner.sv
test/pressure_watermark_tuner_tb.sv
